>>> design/rnsp_pkg.sv
// ----------------------------------------------------------------------------
// rnsp_pkg
// Shared types, character codes, status codes and digit decoding for the
// radix number string parser.
// ----------------------------------------------------------------------------
package rnsp_pkg;

  // ascii codes
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_POINT   = 8'h2e;

  // result status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_BAD_CHAR  = 3'd1;
  localparam logic [2:0] STAT_LATE_DIG  = 3'd2;
  localparam logic [2:0] STAT_TWO_POINT = 3'd3;
  localparam logic [2:0] STAT_OVERFLOW  = 3'd4;

  // parse phase
  localparam logic [1:0] PH_NONE   = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_CLOSED = 2'd2;

  localparam logic [5:0] RADIX_RESET   = 6'd10;
  localparam logic [5:0] RADIX_DEFAULT = 6'd10;
  localparam logic [5:0] RADIX_MIN     = 6'd2;
  localparam logic [5:0] RADIX_MAX     = 6'd36;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } digit_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic digit_t digit_of(input logic [7:0] c);
    digit_t d;
    d.ok  = 1'b0;
    d.val = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.ok  = 1'b1;
      d.val = 6'(c - CH_ZERO);
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      d.ok  = 1'b1;
      d.val = 6'(c - CH_UPPER_A) + 6'd10;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      d.ok  = 1'b1;
      d.val = 6'(c - CH_LOWER_A) + 6'd10;
    end
    return d;
  endfunction

  function automatic logic [5:0] eff_radix(input logic [5:0] r);
    logic [5:0] e;
    e = r;
    if (r == '0) begin
      e = RADIX_DEFAULT;
    end else if (r < RADIX_MIN) begin
      e = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      e = RADIX_MAX;
    end
    return e;
  endfunction

endpackage

>>> design/rnsp_mul.sv
// ----------------------------------------------------------------------------
// rnsp_mul
// Shared weight multiplier: place weight times a six bit factor (digit value
// or radix), with a flag when the product leaves the magnitude range.
// ----------------------------------------------------------------------------
module rnsp_mul #(
  parameter int VALUE_BITS = 48
) (
  input  logic [VALUE_BITS-1:0] weight_i,
  input  logic [5:0]            factor_i,
  output logic [VALUE_BITS-1:0] prod_o,
  output logic                  over_o
);

  logic [VALUE_BITS+5:0] full;

  assign full   = (VALUE_BITS+6)'(weight_i) * (VALUE_BITS+6)'(factor_i);
  assign prod_o = full[VALUE_BITS-1:0];
  assign over_o = |full[VALUE_BITS+5:VALUE_BITS];

endmodule

>>> design/rnsp_div.sv
// ----------------------------------------------------------------------------
// rnsp_div
// Restoring divider, one quotient bit per cycle. The dividend is the digit
// magnitude shifted up by the fraction bits; the quotient is the fixed-point
// magnitude truncated toward zero.
// ----------------------------------------------------------------------------
module rnsp_div #(
  parameter int VALUE_BITS    = 48,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [VALUE_BITS+FRACTION_BITS-1:0] dividend_i,
  input  logic [VALUE_BITS-1:0]               divisor_i,
  output rnsp_pkg::div_stat_t                 stat_o,
  output logic [VALUE_BITS+FRACTION_BITS-1:0] quotient_o
);
  import rnsp_pkg::*;

  localparam int QW = VALUE_BITS + FRACTION_BITS;
  localparam int CW = $clog2(QW + 1);

  logic [VALUE_BITS-1:0] rem_q;
  logic [QW-1:0]         quo_q;
  logic [CW-1:0]         cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [VALUE_BITS:0]   rem_shift;
  logic [VALUE_BITS:0]   rem_sub;
  logic                  take;

  assign rem_shift = {rem_q, quo_q[QW-1]};
  assign take      = rem_shift >= {1'b0, divisor_i};
  assign rem_sub   = rem_shift - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= take ? rem_sub[VALUE_BITS-1:0] : rem_shift[VALUE_BITS-1:0];
      quo_q <= {quo_q[QW-2:0], take};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

>>> design/radix_number_string_parser_unit.sv
// ----------------------------------------------------------------------------
// radix_number_string_parser_unit
// Parses a number string fed last character first into signed fixed point.
// ----------------------------------------------------------------------------
// Characters arrive rightmost first, one item per handshake. A non-digit
// character is accepted and then decoded; a digit adds a weight step, since
// the one shared multiplier is used twice: digit times place weight, then
// place weight times radix. The item marked last is followed by a setup
// step, a restoring division (skipped on error) and result loading; the
// result sits in an output register while the next string is taken, and a
// further last item waits until it has gone. The user must write the radix
// register (0 means ten) only while the block is idle; it is not enforced.
module radix_number_string_parser_unit #(
  parameter int VALUE_BITS    = 48,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [5:0]            cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            char_code_i,
  input  logic                  is_last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            status_o,
  output logic signed [VALUE_BITS-1:0] value_o
);
  import rnsp_pkg::*;

  localparam int QW = VALUE_BITS + FRACTION_BITS;
  localparam logic [VALUE_BITS-1:0] MAG = {VALUE_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHAR,
    S_WEIGHT,
    S_FINISH,
    S_DIV,
    S_RESULT
  } state_e;

  state_e state_q, state_d;

  logic [5:0]            radix_q, radix_d;
  logic [7:0]            char_q;
  logic                  last_q;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [VALUE_BITS-1:0] pw_q, pw_d;
  logic [VALUE_BITS-1:0] fdiv_q, fdiv_d;
  logic [1:0]            phase_q, phase_d;
  logic                  point_q, point_d;
  logic                  neg_q, neg_d;
  logic [2:0]            err_q, err_d;
  logic                  out_valid_q, out_valid_d;
  logic [2:0]            status_q, status_d;
  logic [VALUE_BITS-1:0] value_q, value_d;

  logic [5:0]            radix_eff;
  digit_t                dig;
  logic [5:0]            mul_factor;
  logic [VALUE_BITS-1:0] prod;
  logic                  prod_over;
  logic [VALUE_BITS:0]   acc_sum;
  logic                  div_start;
  div_stat_t             div_stat;
  logic [QW-1:0]         quotient;
  logic [QW-1:0]         bound;
  state_e                after_char;

  assign radix_eff  = eff_radix(radix_q);
  assign dig        = digit_of(char_q);
  assign mul_factor = (state_q == S_WEIGHT) ? radix_eff : dig.val;
  assign acc_sum    = {1'b0, acc_q} + {1'b0, prod};
  assign after_char = last_q ? S_FINISH : S_IDLE;
  assign bound      = (QW'(1) << (VALUE_BITS - 1)) - QW'(!neg_q);

  rnsp_mul #(
    .VALUE_BITS(VALUE_BITS)
  ) u_mul (
    .weight_i(pw_q),
    .factor_i(mul_factor),
    .prod_o  (prod),
    .over_o  (prod_over)
  );

  rnsp_div #(
    .VALUE_BITS   (VALUE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(QW'(acc_q) << FRACTION_BITS),
    .divisor_i (fdiv_q),
    .stat_o    (div_stat),
    .quotient_o(quotient)
  );

  always_comb begin
    state_d     = state_q;
    radix_d     = cfg_we_i ? cfg_data_i : radix_q;
    acc_d       = acc_q;
    pw_d        = pw_q;
    fdiv_d      = fdiv_q;
    phase_d     = phase_q;
    point_d     = point_q;
    neg_d       = neg_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    value_d     = value_q;
    div_start   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CHAR;
        end
      end
      S_CHAR: begin
        state_d = after_char;
        if (err_q == STAT_OK) begin
          if (dig.ok) begin
            if (dig.val >= radix_eff) begin
              err_d = STAT_BAD_CHAR;
            end else if (phase_q == PH_CLOSED) begin
              err_d = STAT_LATE_DIG;
            end else if (dig.val != '0 && (pw_q == MAG || prod_over)) begin
              err_d = STAT_OVERFLOW;
            end else if (dig.val != '0 && acc_sum[VALUE_BITS]) begin
              err_d = STAT_OVERFLOW;
            end else begin
              if (dig.val != '0) begin
                acc_d = acc_sum[VALUE_BITS-1:0];
              end
              state_d = S_WEIGHT;
            end
          end else if (char_q == CH_SPACE) begin
            if (phase_q == PH_DIGITS) begin
              phase_d = PH_CLOSED;
            end
          end else if (phase_q == PH_DIGITS && (char_q == CH_MINUS || char_q == CH_PLUS)) begin
            phase_d = PH_CLOSED;
            if (char_q == CH_MINUS) begin
              neg_d = 1'b1;
            end
          end else if (phase_q == PH_DIGITS && char_q == CH_POINT) begin
            if (point_q) begin
              err_d = STAT_TWO_POINT;
            end else if (pw_q == MAG) begin
              err_d = STAT_OVERFLOW;
            end else begin
              point_d = 1'b1;
              fdiv_d  = pw_q;
            end
          end else begin
            err_d = STAT_BAD_CHAR;
          end
        end
      end
      S_WEIGHT: begin
        pw_d    = prod_over ? MAG : prod;
        phase_d = PH_DIGITS;
        state_d = after_char;
      end
      S_FINISH: begin
        if (err_q == STAT_OK) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (err_q != STAT_OK) begin
            status_d = err_q;
            value_d  = '0;
          end else if (quotient > bound) begin
            status_d = STAT_OVERFLOW;
            value_d  = '0;
          end else begin
            status_d = STAT_OK;
            value_d  = neg_q ? VALUE_BITS'(0) - quotient[VALUE_BITS-1:0]
                             : quotient[VALUE_BITS-1:0];
          end
          acc_d   = '0;
          pw_d    = VALUE_BITS'(1);
          fdiv_d  = VALUE_BITS'(1);
          phase_d = PH_NONE;
          point_d = 1'b0;
          neg_d   = 1'b0;
          err_d   = STAT_OK;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radix_q     <= RADIX_RESET;
      acc_q       <= '0;
      pw_q        <= VALUE_BITS'(1);
      fdiv_q      <= VALUE_BITS'(1);
      phase_q     <= PH_NONE;
      point_q     <= 1'b0;
      neg_q       <= 1'b0;
      err_q       <= STAT_OK;
      out_valid_q <= 1'b0;
      status_q    <= STAT_OK;
      value_q     <= '0;
    end else begin
      state_q     <= state_d;
      radix_q     <= radix_d;
      acc_q       <= acc_d;
      pw_q        <= pw_d;
      fdiv_q      <= fdiv_d;
      phase_q     <= phase_d;
      point_q     <= point_d;
      neg_q       <= neg_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      value_q     <= value_d;
    end
  end

  // input item holding register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_code_i;
      last_q <= is_last_i;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_o     = value_q;

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> state_q == S_DIV)
    else $error("divider busy outside divide state");

  a_weight_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pw_q != '0)
    else $error("place weight is zero");

  a_fdiv_le_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fdiv_q <= pw_q)
    else $error("fraction divisor above place weight");

  a_acc_below_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_WEIGHT && pw_q != MAG) |-> acc_q < pw_q)
    else $error("accumulator not below place weight");

  a_error_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STAT_OK) |-> value_o == '0)
    else $error("nonzero value with error status");

endmodule

>>> tb/rnsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnsp_checker
// Watches both channels of the radix number string parser, works out the
// number each string should give and compares it with the results, oldest
// first. The mismatch count and the number of results still owed go to the
// testbench top.
// ----------------------------------------------------------------------------
module rnsp_checker #(
  parameter int VALUE_BITS    = 48,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [5:0]            cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [7:0]            char_code_i,
  input  logic                  is_last_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [2:0]            status_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output int                    mismatches_o,
  output int                    pending_o
);
  import rnsp_pkg::*;

  localparam logic [63:0] MAG_MASK  = (64'd1 << VALUE_BITS) - 64'd1;
  localparam logic [63:0] NEG_LIMIT = 64'd1 << (VALUE_BITS - 1);
  localparam logic [7:0]  NO_DIGIT  = 8'hff;

  typedef struct packed {
    logic [2:0]            status;
    logic [VALUE_BITS-1:0] value;
  } number_t;

  logic [5:0]  radix_q;
  logic [63:0] magnitude;
  logic [63:0] weight;
  logic [63:0] divisor;
  logic [1:0]  parse_phase;
  logic        point_seen;
  logic        negative;
  logic [2:0]  parse_error;
  number_t     expected_numbers[$];
  number_t     want;
  number_t     got;
  int          mismatch_count;

  function automatic logic [63:0] radix_value(input logic [5:0] r);
    if (r == 6'd0) return 64'(RADIX_DEFAULT);
    if (r < RADIX_MIN) return 64'(RADIX_MIN);
    if (r > RADIX_MAX) return 64'(RADIX_MAX);
    return 64'(r);
  endfunction

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return c - CH_UPPER_A + 8'd10;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return c - CH_LOWER_A + 8'd10;
    return NO_DIGIT;
  endfunction

  task automatic clear_parse();
    magnitude   = 64'd0;
    weight      = 64'd1;
    divisor     = 64'd1;
    parse_phase = PH_NONE;
    point_seen  = 1'b0;
    negative    = 1'b0;
    parse_error = STAT_OK;
  endtask

  task automatic absorb_char(input logic [7:0] c);
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] prod;
    logic [7:0]  d;
    logic        too_big;
    r = radix_value(radix_q);
    d = digit_value(c);
    too_big = 1'b0;
    if (d != NO_DIGIT) begin
      v = 64'(d);
      if (v >= r) begin
        parse_error = STAT_BAD_CHAR;
      end else if (parse_phase == PH_CLOSED) begin
        parse_error = STAT_LATE_DIG;
      end else begin
        if (v != 64'd0) begin
          if (weight == MAG_MASK || weight > MAG_MASK / v) begin
            too_big = 1'b1;
          end else begin
            prod = v * weight;
            if (prod > MAG_MASK - magnitude) too_big = 1'b1;
            else magnitude = magnitude + prod;
          end
        end
        if (too_big) begin
          parse_error = STAT_OVERFLOW;
        end else begin
          if (weight > MAG_MASK / r) weight = MAG_MASK;
          else weight = weight * r;
          parse_phase = PH_DIGITS;
        end
      end
    end else if (c == CH_SPACE) begin
      if (parse_phase == PH_DIGITS) parse_phase = PH_CLOSED;
    end else if (parse_phase == PH_DIGITS && (c == CH_MINUS || c == CH_PLUS)) begin
      parse_phase = PH_CLOSED;
      if (c == CH_MINUS) negative = 1'b1;
    end else if (parse_phase == PH_DIGITS && c == CH_POINT) begin
      if (point_seen) begin
        parse_error = STAT_TWO_POINT;
      end else if (weight == MAG_MASK) begin
        parse_error = STAT_OVERFLOW;
      end else begin
        point_seen = 1'b1;
        divisor    = weight;
      end
    end else begin
      parse_error = STAT_BAD_CHAR;
    end
  endtask

  // integer part, then fraction bits by restoring division, truncated
  task automatic form_number(output number_t n);
    logic [63:0] whole;
    logic [63:0] rest;
    logic [63:0] gap;
    logic [63:0] frac;
    logic [63:0] total;
    logic [63:0] bound;
    n.status = parse_error;
    n.value  = '0;
    if (parse_error == STAT_OK) begin
      whole = magnitude / divisor;
      rest  = magnitude % divisor;
      frac  = 64'd0;
      if (whole > (NEG_LIMIT >> FRACTION_BITS)) begin
        n.status = STAT_OVERFLOW;
      end else begin
        for (int i = 0; i < FRACTION_BITS; i++) begin
          gap  = divisor - rest;
          frac = frac << 1;
          if (rest >= gap) begin
            rest = rest - gap;
            frac = frac | 64'd1;
          end else begin
            rest = rest << 1;
          end
        end
        total = (whole << FRACTION_BITS) + frac;
        bound = negative ? NEG_LIMIT : NEG_LIMIT - 64'd1;
        if (total > bound) n.status = STAT_OVERFLOW;
        else n.value = VALUE_BITS'(negative ? 64'd0 - total : total);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input number_t exp_n,
                                 input number_t act_n);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected status %0d value %0d, got status %0d value %0d",
               $realtime, what, exp_n.status, $signed(exp_n.value),
               act_n.status, $signed(act_n.value));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q = RADIX_RESET;
      clear_parse();
      expected_numbers.delete();
      mismatch_count = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        radix_q = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        got.status = status_i;
        got.value  = value_i;
        if (expected_numbers.size() == 0) begin
          report_mismatch("result with nothing expected", '0, got);
        end else begin
          want = expected_numbers.pop_front();
          if (got.status !== want.status || got.value !== want.value) begin
            report_mismatch("wrong result", want, got);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (parse_error == STAT_OK) begin
          absorb_char(char_code_i);
        end
        if (is_last_i) begin
          form_number(want);
          expected_numbers.push_back(want);
          clear_parse();
        end
      end
      mismatches_o <= mismatch_count;
      pending_o    <= expected_numbers.size();
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds number strings, last character first, to the radix number string
// parser under several radix settings and idle patterns, including a long
// stall of the result side, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module testbench;
  import rnsp_pkg::*;

  localparam int          VALUE_BITS     = 48;
  localparam int          FRACTION_BITS  = 16;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          DRAIN_CYCLES   = 100;
  localparam int          RANDOM_ITEMS   = 20;
  localparam logic [63:0] MAG_MASK       = (64'd1 << VALUE_BITS) - 64'd1;
  localparam logic [63:0] INT_LIMIT      = 64'd1 << (VALUE_BITS - 1 - FRACTION_BITS);

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [5:0]                   cfg_data_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [7:0]                   char_code_i;
  logic                         is_last_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [2:0]                   status_o;
  logic signed [VALUE_BITS-1:0] value_o;

  int         mismatches;
  int         pending;
  int         snd_idle = 24;
  int         rcv_idle = 69;
  logic       hold_req = 1'b0;
  logic       hold_rcv = 1'b0;
  int         radix_now = 10;
  int         items_sent = 0;
  int         strings_sent = 0;
  int         settings_used = 1;
  int         stall_cycles = 0;
  logic [7:0] text[$];

  radix_number_string_parser_unit #(
    .VALUE_BITS   (VALUE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .char_code_i(char_code_i),
    .is_last_i  (is_last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .value_o    (value_o)
  );

  rnsp_checker #(
    .VALUE_BITS   (VALUE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) number_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status_o),
    .value_i     (value_o),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rcv) out_ready_i <= 1'b0;
      else out_ready_i <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // long hold-off on the result side so the block fills and stalls its input
  initial begin
    @(posedge hold_req);
    hold_rcv <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rcv <= 1'b0;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (in_valid_i && !in_ready_o) stall_cycles++;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("radix_number_string_parser_unit test failed");
    $finish;
  end

  function automatic logic [7:0] digit_char(input int v);
    if (v < 10) return CH_ZERO + 8'(v);
    if ($urandom_range(1) == 0) return CH_UPPER_A + 8'(v - 10);
    return CH_LOWER_A + 8'(v - 10);
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    is_last_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // rightmost character goes first, the leftmost one closes the string
  task automatic feed_text();
    for (int i = text.size() - 1; i >= 0; i--) begin
      send_char(text[i], i == 0);
    end
    strings_sent++;
  endtask

  task automatic feed_literal(input string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    feed_text();
  endtask

  task automatic push_value(input logic [63:0] num);
    logic [7:0]  digs[$];
    logic [63:0] rest;
    rest = num;
    do begin
      digs.push_front(digit_char(int'(rest % 64'(radix_now))));
      rest = rest / 64'(radix_now);
    end while (rest != 64'd0);
    foreach (digs[i]) text.push_back(digs[i]);
  endtask

  task automatic wait_quiet(input int cycles);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic write_radix(input logic [5:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (v == 6'd0) radix_now = int'(RADIX_DEFAULT);
    else if (v < RADIX_MIN) radix_now = int'(RADIX_MIN);
    else if (v > RADIX_MAX) radix_now = int'(RADIX_MAX);
    else radix_now = int'(v);
    settings_used++;
  endtask

  task automatic run_directed();
    feed_literal("0");
    feed_literal(" ");
    feed_literal("+7");
    feed_literal("-0.5");
    feed_literal(".5");
    feed_literal("5.");
    feed_literal("9 9");
    feed_literal("..1");
    feed_literal("a");
    feed_literal("--1");
    feed_literal(" 1 ");
    text.delete();
    text.push_back(8'hff);
    feed_text();
  endtask

  // most negative value, first positive overflow, magnitude limits, saturated point
  task automatic run_edges();
    logic [63:0] w;
    int          zeros;
    text.delete();
    text.push_back(CH_MINUS);
    push_value(INT_LIMIT);
    feed_text();
    text.delete();
    push_value(INT_LIMIT);
    feed_text();
    if (radix_now >= 8) begin
      text.delete();
      push_value(MAG_MASK);
      feed_text();
      text.delete();
      push_value(MAG_MASK + 64'd1);
      feed_text();
    end
    if (radix_now >= 16) begin
      w = 64'd1;
      zeros = 0;
      while (w != MAG_MASK) begin
        if (w > MAG_MASK / 64'(radix_now)) w = MAG_MASK;
        else w = w * 64'(radix_now);
        zeros++;
      end
      text.delete();
      text.push_back(CH_ZERO + 8'd1);
      text.push_back(CH_POINT);
      repeat (zeros) text.push_back(CH_ZERO);
      feed_text();
    end
  endtask

  task automatic build_random();
    int         mode;
    int         n_int;
    int         n_frac;
    int         pos;
    logic       has_point;
    logic [7:0] c;
    text.delete();
    mode = $urandom_range(99);
    if (mode >= 90) begin
      repeat ($urandom_range(1, 5)) text.push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) text.push_back(CH_SPACE);
      case ($urandom_range(2))
        1: text.push_back(CH_MINUS);
        2: text.push_back(CH_PLUS);
        default: ;
      endcase
      n_int     = ($urandom_range(9) == 0) ? $urandom_range(6, 14) : $urandom_range(0, 5);
      has_point = ($urandom_range(2) == 0);
      n_frac    = ($urandom_range(11) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 4);
      if (!has_point) n_frac = 0;
      if (n_int == 0 && n_frac == 0) n_int = 1;
      repeat (n_int) text.push_back(digit_char($urandom_range(radix_now - 1)));
      if (has_point) text.push_back(CH_POINT);
      repeat (n_frac) text.push_back(digit_char($urandom_range(radix_now - 1)));
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) text.push_back(CH_SPACE);
      // broken strings: one stray character somewhere
      if (mode >= 65) begin
        pos = $urandom_range(text.size());
        case ($urandom_range(4))
          0: c = 8'($urandom_range(255));
          1: c = CH_POINT;
          2: c = CH_MINUS;
          3: c = CH_SPACE;
          default: c = digit_char($urandom_range(35));
        endcase
        text.insert(pos, c);
      end
    end
  endtask

  task automatic run_random(input int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      build_random();
      feed_text();
    end
  endtask

  initial begin : stimulus
    logic [5:0] plan[$];
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    char_code_i <= '0;
    is_last_i   <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    plan = {6'd0, 6'd2, 6'd36, 6'd1, 6'd63, 6'd16, 6'd7, 6'd0};
    plan[7] = 6'($urandom_range(63));
    foreach (plan[g]) begin
      if (g == 3) begin
        snd_idle = 69;
        rcv_idle <= 24;
      end
      if (g == 6) begin
        snd_idle = 0;
        rcv_idle <= 0;
      end
      wait_quiet(SETTLE_CYCLES);
      write_radix(plan[g]);
      if (g == 6) hold_req <= 1'b1;
      run_edges();
      run_random(RANDOM_ITEMS);
    end
    wait_quiet(DRAIN_CYCLES);
    $display("fed %0d characters in %0d strings under %0d radix settings",
             items_sent, strings_sent, settings_used);
    $display("input waited on ready for %0d cycles", stall_cycles);
    if (mismatches == 0 && pending == 0) begin
      $display("radix_number_string_parser_unit test passed");
    end else begin
      $display("radix_number_string_parser_unit test failed");
    end
    $finish;
  end

endmodule
